>>> rtl/s2h_pkg.sv
// Package for the scan code to HID report converter: types, constants and lookup tables.
`default_nettype none

package s2h_pkg;

  // Lookup constants
  localparam int unsigned REPORT_SLOTS = 6;
  localparam logic [6:0]  PLAIN_COUNT  = 7'h59;
  localparam logic [7:0]  MOD_MARK     = 8'hFF;
  localparam logic [7:0]  RELEASE_BIT  = 8'h80;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPDATE,
    ST_REPORT
  } s2h_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // load the accepted word
    logic decode;    // register the table lookup
    logic update;    // apply the code to the held state
    logic load_out;  // copy the report into the output register
  } s2h_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic report_pending;  // code recognized and host ready
  } s2h_status_t;

  // Result of a table lookup
  typedef struct packed {
    logic       found;
    logic [7:0] usage;
    logic [7:0] mod;
  } s2h_lookup_t;

  // Plain code to HID usage, 0 = no key, MOD_MARK = modifier
  localparam logic [7:0] PLAIN_USAGE [89] = '{
    8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B,
    8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
    8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'hFF, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
    8'h34, 8'h35, 8'hFF, 8'h31, 8'h1D, 8'h1B, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hFF, 8'h55,
    8'hFF, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
    8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
    8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
    8'h5A, 8'h5B, 8'h62, 8'h63, 8'h46, 8'h00, 8'h00, 8'h44,
    8'h45
  };

  // Modifier bit of a plain modifier key
  function automatic logic [7:0] plain_mod_bit(input logic [6:0] code);
    logic [7:0] bit_mask;
    unique case (code)
      7'h1D:   bit_mask = 8'h01;
      7'h2A:   bit_mask = 8'h02;
      7'h38:   bit_mask = 8'h04;
      7'h36:   bit_mask = 8'h20;
      default: bit_mask = 8'h00;
    endcase
    return bit_mask;
  endfunction

  // Plain code lookup, empty entries and codes past the table are unknown
  function automatic s2h_lookup_t plain_lookup(input logic [6:0] code);
    s2h_lookup_t res;
    res.found = 1'b0;
    res.usage = 8'h00;
    res.mod   = 8'h00;
    if (code < PLAIN_COUNT) begin
      res.usage = PLAIN_USAGE[code];
      res.mod   = plain_mod_bit(code);
      res.found = (res.usage != 8'h00);
    end
    return res;
  endfunction

  // Extended (E0-prefixed) code lookup, exact match only
  function automatic s2h_lookup_t ext_lookup(input logic [15:0] code);
    s2h_lookup_t res;
    res.found = 1'b1;
    res.mod   = 8'h00;
    res.usage = MOD_MARK;
    unique case (code)
      16'hE01C: res.usage = 8'h58;
      16'hE01D: res.mod   = 8'h10;
      16'hE035: res.usage = 8'h54;
      16'hE037: res.usage = 8'h46;
      16'hE038: res.mod   = 8'h40;
      16'hE046: res.usage = 8'h48;
      16'hE047: res.usage = 8'h4A;
      16'hE048: res.usage = 8'h52;
      16'hE049: res.usage = 8'h4B;
      16'hE04B: res.usage = 8'h50;
      16'hE04D: res.usage = 8'h4F;
      16'hE04F: res.usage = 8'h4D;
      16'hE050: res.usage = 8'h51;
      16'hE051: res.usage = 8'h4E;
      16'hE052: res.usage = 8'h49;
      16'hE053: res.usage = 8'h4C;
      16'hE05B: res.mod   = 8'h08;
      16'hE05C: res.mod   = 8'h80;
      16'hE05D: res.usage = 8'h65;
      default: begin
        res.found = 1'b0;
        res.usage = 8'h00;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/s2h_ctrl.sv
// Controller state machine: sequences capture, decode, update and report load.
`default_nettype none

module s2h_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  s2h_pkg::s2h_status_t status_i,
  output s2h_pkg::s2h_cmd_t    cmd_o
);
  import s2h_pkg::*;

  s2h_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Output register can take a report this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // State register and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_REPORT;
      ST_REPORT: if (!status_i.report_pending || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: cmd_o.decode = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_REPORT: begin
        if (status_i.report_pending && out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/s2h_datapath.sv
// Datapath: input register, table lookup, modifier and key slot state, report register.
`default_nettype none

module s2h_datapath #(
  parameter int KEY_SLOTS = 6
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  s2h_pkg::s2h_cmd_t    cmd_i,
  output s2h_pkg::s2h_status_t status_o,
  input  wire  [15:0]          scan_code_i,
  input  wire                  host_ready_i,
  output logic [7:0]           modifier_byte_o,
  output logic [7:0]           report_keys_o [s2h_pkg::REPORT_SLOTS]
);
  import s2h_pkg::*;

  // Captured word
  logic [15:0] code_q;
  logic        host_q;

  // Decoded code
  logic        found_q;
  logic        release_q;
  logic [7:0]  usage_q;
  logic [7:0]  mod_q;
  logic        dec_host_q;

  // Held state
  logic [7:0]  mods_q, mods_d;
  logic [7:0]  keys_q [KEY_SLOTS];
  logic [7:0]  keys_d [KEY_SLOTS];
  logic [7:0]  keys_ext [KEY_SLOTS+1];

  // Report register
  logic [7:0]  rep_mod_q;
  logic [7:0]  rep_keys_q [REPORT_SLOTS];

  logic [15:0]   lookup_code;
  s2h_lookup_t   lookup;
  logic [KEY_SLOTS-1:0] hit;
  logic [KEY_SLOTS-1:0] first_free;
  logic [KEY_SLOTS-1:0] from_hit;
  logic          any_hit;

  // Release flag cleared before lookup
  assign lookup_code = {code_q[15:8], code_q[7:0] & ~RELEASE_BIT};

  always_comb begin
    if (lookup_code[15:8] != 8'h00) begin
      lookup = ext_lookup(lookup_code);
    end else begin
      lookup = plain_lookup(lookup_code[6:0]);
    end
  end

  // Input and decode registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      code_q <= scan_code_i;
      host_q <= host_ready_i;
    end
    if (cmd_i.decode) begin
      release_q  <= code_q[7];
      usage_q    <= lookup.usage;
      mod_q      <= lookup.mod;
      dec_host_q <= host_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.decode) begin
      found_q <= lookup.found;
    end
  end

  // Slot match, first free slot and slots at or past the match
  always_comb begin
    logic taken;
    logic seen;
    taken = 1'b0;
    seen  = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      hit[j]        = (keys_q[j] == usage_q);
      first_free[j] = (keys_q[j] == 8'h00) && !taken;
      taken         = taken || (keys_q[j] == 8'h00);
      seen          = seen || hit[j];
      from_hit[j]   = seen;
      keys_ext[j]   = keys_q[j];
    end
    keys_ext[KEY_SLOTS] = 8'h00;
  end

  assign any_hit = |hit;

  // Apply press or release
  always_comb begin
    mods_d = mods_q;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      keys_d[j] = keys_q[j];
    end
    if (cmd_i.update && found_q) begin
      if (usage_q == MOD_MARK) begin
        mods_d = release_q ? (mods_q & ~mod_q) : (mods_q | mod_q);
      end else if (release_q) begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
          if (from_hit[j]) keys_d[j] = keys_ext[j+1];
        end
      end else if (!any_hit) begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
          if (first_free[j]) keys_d[j] = usage_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= 8'h00;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        keys_q[j] <= 8'h00;
      end
    end else begin
      mods_q <= mods_d;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        keys_q[j] <= keys_d[j];
      end
    end
  end

  // Report register, slots beyond the held list read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rep_mod_q <= mods_q;
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        rep_keys_q[i] <= (i < KEY_SLOTS) ? keys_ext[(i < KEY_SLOTS) ? i : KEY_SLOTS] : 8'h00;
      end
    end
  end

  assign status_o.report_pending = found_q && dec_host_q;
  assign modifier_byte_o         = rep_mod_q;

  always_comb begin
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      report_keys_o[i] = rep_keys_q[i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/scancode_to_hid_report_core.sv
// Top level: set-1 scan code to HID boot keyboard report converter.
// Sequence: a word is captured when accepted, then decoded, applied and its report
// loaded in the report step; a new word is accepted only once the controller is back
// in idle after capture, decode, update and report load; a report waiting for
// out_ready holds the next word in its report step only.
// Reset: asynchronous, active low; clears modifiers, all key slots and valids.
`default_nettype none

module scancode_to_hid_report_core #(
  parameter int KEY_SLOTS = 6
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [15:0] scan_code_i,
  input  wire         host_ready_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  modifier_byte_o,
  output logic [7:0]  key_slot0_o,
  output logic [7:0]  key_slot1_o,
  output logic [7:0]  key_slot2_o,
  output logic [7:0]  key_slot3_o,
  output logic [7:0]  key_slot4_o,
  output logic [7:0]  key_slot5_o
);
  import s2h_pkg::*;

  s2h_cmd_t    cmd;
  s2h_status_t status;
  logic [7:0]  report_keys [REPORT_SLOTS];

  // Controller
  s2h_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  s2h_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .scan_code_i     (scan_code_i),
    .host_ready_i    (host_ready_i),
    .modifier_byte_o (modifier_byte_o),
    .report_keys_o   (report_keys)
  );

  assign key_slot0_o = report_keys[0];
  assign key_slot1_o = report_keys[1];
  assign key_slot2_o = report_keys[2];
  assign key_slot3_o = report_keys[3];
  assign key_slot4_o = report_keys[4];
  assign key_slot5_o = report_keys[5];

endmodule

`default_nettype wire
